// ===== hdl/pt3d_pkg.sv =====
// Shared types and constants for the 3D point transform.
`default_nettype none

package pt3d_pkg;

  // Default coordinate width (Q16.16)
  localparam int COORD_WIDTH_DEF = 32;

  // Register port
  localparam int REG_DATA_W  = 32;
  localparam int REG_INDEX_W = 3;

  // Fixed-point formats
  localparam int Q_FRAC  = 16;  // Q16.16 fraction bits
  localparam int CS_W    = 16;  // packed cosine / sine half-word
  localparam int CS_FRAC = 14;  // Q1.14 fraction bits

  // Headroom for growth through the three rotations
  localparam int ROT_GROWTH = 6;

  // Rotation axes
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  typedef enum logic [1:0] {
    MODE_MOVE   = 2'd0,
    MODE_ROTATE = 2'd1,
    MODE_SCALE  = 2'd2
  } mode_t;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_CENTER_X = 3'd1,
    REG_CENTER_Y = 3'd2,
    REG_CENTER_Z = 3'd3,
    REG_PARAM_X  = 3'd4,
    REG_PARAM_Y  = 3'd5,
    REG_PARAM_Z  = 3'd6
  } reg_index_t;

  // Load enables of the scale pipeline stages
  typedef struct packed {
    logic st2;
    logic st3;
    logic st4;
  } scl_ld_t;

endpackage

`default_nettype wire

// ===== hdl/pt3d_rot.sv =====
// One registered rotation stage about a fixed axis.
`default_nettype none

module pt3d_rot
  import pt3d_pkg::*;
#(
  parameter int ROT_W = COORD_WIDTH_DEF + 1 + ROT_GROWTH,
  parameter int AXIS  = AXIS_X
) (
  input  logic                    clk,
  input  logic                    ld,
  input  logic                    rotate,
  input  logic [REG_DATA_W-1:0]   cs,
  input  logic signed [ROT_W-1:0] p_in  [3],
  output logic signed [ROT_W-1:0] p_out [3]
);

  // the pair of coordinates this axis turns
  localparam int IA = (AXIS == AXIS_X) ? 1 : 0;
  localparam int IB = (AXIS == AXIS_Z) ? 1 : 2;

  logic signed [ROT_W-1:0]      a, b;
  logic signed [CS_W-1:0]       c, s;
  logic signed [ROT_W+CS_W-1:0] p_ac, p_bs, p_as, p_bc, n_as;
  logic signed [ROT_W-1:0]      a_new, b_new;
  logic signed [ROT_W-1:0]      p_next [3];

  always_comb begin
    a = p_in[IA];
    b = p_in[IB];
    c = cs[REG_DATA_W-1:REG_DATA_W-CS_W];
    s = cs[CS_W-1:0];
    p_ac = a * c;
    p_bs = b * s;
    p_as = a * s;
    p_bc = b * c;
    n_as = -p_as;
    // each term floored on its own before the sum
    a_new = p_ac[ROT_W+CS_FRAC-1:CS_FRAC] + p_bs[ROT_W+CS_FRAC-1:CS_FRAC];
    b_new = n_as[ROT_W+CS_FRAC-1:CS_FRAC] + p_bc[ROT_W+CS_FRAC-1:CS_FRAC];
    p_next = p_in;
    if (rotate) begin
      p_next[IA] = a_new;
      p_next[IB] = b_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      p_out <= p_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pt3d_scale.sv =====
// Three-stage scale multiplier: floor(d * k / 2^16) per axis.
`default_nettype none

module pt3d_scale
  import pt3d_pkg::*;
#(
  parameter int DIFF_W = COORD_WIDTH_DEF + 1,
  parameter int SCL_W  = DIFF_W + REG_DATA_W - Q_FRAC
) (
  input  logic                         clk,
  input  scl_ld_t                      ld,
  input  logic signed [DIFF_W-1:0]     d [3],
  input  logic        [REG_DATA_W-1:0] k [3],
  output logic signed [SCL_W-1:0]      q [3]
);

  localparam int HI_W = DIFF_W - Q_FRAC + REG_DATA_W;
  localparam int LO_W = Q_FRAC + 1 + REG_DATA_W;

  // d = dh * 2^16 + dl, so floor(d*k/2^16) = dh*k + floor(dl*k/2^16)
  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [HI_W-1:0]       ph;
    logic signed [LO_W-1:0]       pl;
    logic signed [REG_DATA_W:0]   pl_q;
    logic signed [SCL_W-1:0]      sum;

    always_comb begin
      pl = $signed({1'b0, d[i][Q_FRAC-1:0]}) * $signed(k[i]);
    end

    always_ff @(posedge clk) begin
      if (ld.st2) begin
        ph   <= $signed(d[i][DIFF_W-1:Q_FRAC]) * $signed(k[i]);
        pl_q <= pl[LO_W-1:Q_FRAC];
      end
      if (ld.st3) begin
        sum <= SCL_W'(ph) + SCL_W'(pl_q);
      end
      if (ld.st4) begin
        q[i] <= sum;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pt3d_out.sv =====
// Output stage: add the centre back (rotate and scale), saturate, register the result.
`default_nettype none

module pt3d_out
  import pt3d_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ROT_W       = COORD_WIDTH_DEF + 1 + ROT_GROWTH,
  parameter int SCL_W       = COORD_WIDTH_DEF + 1 + REG_DATA_W - Q_FRAC
) (
  input  logic                          clk,
  input  logic                          ld,
  input  logic [1:0]                    mode,
  input  logic signed [ROT_W-1:0]       r [3],
  input  logic signed [SCL_W-1:0]       q [3],
  input  logic signed [REG_DATA_W-1:0]  center [3],
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          saturated
);

  localparam int SUM_W = ((ROT_W > SCL_W) ? ROT_W : SCL_W) + 1;
  localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [SUM_W-1:0]       opnd [3];
  logic signed [SUM_W-1:0]       addend [3];
  logic signed [SUM_W-1:0]       sum [3];
  logic [SUM_W-COORD_WIDTH:0]    top_bits [3];
  logic [COORD_WIDTH-1:0]        res [3];
  logic [2:0]                    clip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (mode == MODE_ROTATE) begin
        opnd[i]   = SUM_W'(r[i]);
        addend[i] = SUM_W'(center[i]);
      end else if (mode == MODE_SCALE) begin
        opnd[i]   = SUM_W'(q[i]);
        addend[i] = SUM_W'(center[i]);
      end else begin
        opnd[i]   = SUM_W'(r[i]);
        addend[i] = '0;
      end
      sum[i]      = opnd[i] + addend[i];
      // in range when everything above the sign bit matches it
      top_bits[i] = sum[i][SUM_W-1:COORD_WIDTH-1];
      clip[i]     = !((&top_bits[i]) || !(|top_bits[i]));
      if (clip[i]) begin
        res[i] = sum[i][SUM_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
        res[i] = sum[i][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_x     <= res[0];
      out_y     <= res[1];
      out_z     <= res[2];
      saturated <= |clip;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/point_transform_3d.sv =====
// 3D point transform (move, rotate about centre, scale about centre), top level.
// Throughput: one point per cycle while the output is not stalled.
// Five pipeline stages, each one multiply or add wide.
// A stall at the output holds the pipe; empty stages still fill behind it.
// Reset (rst, synchronous) clears the stage valid bits and the configuration registers to 0.
`default_nettype none

module point_transform_3d
  import pt3d_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          saturated,
  input  logic                          wr_en,
  input  logic [REG_INDEX_W-1:0]        wr_index,
  input  logic [REG_DATA_W-1:0]         wr_data
);

  localparam int DIFF_W = ((COORD_WIDTH > REG_DATA_W) ? COORD_WIDTH : REG_DATA_W) + 1;
  localparam int ROT_W  = DIFF_W + ROT_GROWTH;
  localparam int SCL_W  = DIFF_W + REG_DATA_W - Q_FRAC;
  localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // configuration
  logic [1:0]                   mode;
  logic signed [REG_DATA_W-1:0] center [3];
  logic [REG_DATA_W-1:0]        param [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_MOVE;
      center <= '{default: '0};
      param  <= '{default: '0};
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MODE:     mode      <= wr_data[1:0];
        REG_CENTER_X: center[0] <= wr_data;
        REG_CENTER_Y: center[1] <= wr_data;
        REG_CENTER_Z: center[2] <= wr_data;
        REG_PARAM_X:  param[0]  <= wr_data;
        REG_PARAM_Y:  param[1]  <= wr_data;
        REG_PARAM_Z:  param[2]  <= wr_data;
        default: ;
      endcase
    end
  end

  // stage valids and load enables; stage 5 is the output register
  logic [4:0] vld;
  logic [4:0] ld;

  assign ld[4] = !vld[4] || out_ready;
  for (genvar k = 0; k < 4; k++) begin : g_ld
    assign ld[k] = !vld[k] || ld[k+1];
  end

  assign in_ready  = ld[0];
  assign out_valid = vld[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) vld[0] <= in_valid;
      for (int k = 1; k < 5; k++) begin
        if (ld[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: offset for move, centre removed for rotate and scale, unused mode passed through
  logic signed [COORD_WIDTH-1:0] pin [3];
  logic signed [DIFF_W-1:0]      s1_next [3];
  logic signed [ROT_W-1:0]       s1 [3];

  assign pin[0] = in_x;
  assign pin[1] = in_y;
  assign pin[2] = in_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (mode == MODE_MOVE) begin
        s1_next[i] = DIFF_W'(pin[i]) + DIFF_W'($signed(param[i]));
      end else if (mode == MODE_ROTATE || mode == MODE_SCALE) begin
        s1_next[i] = DIFF_W'(pin[i]) - DIFF_W'(center[i]);
      end else begin
        s1_next[i] = DIFF_W'(pin[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int i = 0; i < 3; i++) begin
        s1[i] <= ROT_W'(s1_next[i]);
      end
    end
  end

  // stages 2 to 4: rotations about x, y, z in turn
  logic signed [ROT_W-1:0] r2 [3];
  logic signed [ROT_W-1:0] r3 [3];
  logic signed [ROT_W-1:0] r4 [3];
  logic                    rotate;

  assign rotate = (mode == MODE_ROTATE);

  pt3d_rot #(.ROT_W(ROT_W), .AXIS(AXIS_X)) u_rot_x (
    .clk(clk), .ld(ld[1]), .rotate(rotate), .cs(param[0]), .p_in(s1), .p_out(r2)
  );

  pt3d_rot #(.ROT_W(ROT_W), .AXIS(AXIS_Y)) u_rot_y (
    .clk(clk), .ld(ld[2]), .rotate(rotate), .cs(param[1]), .p_in(r2), .p_out(r3)
  );

  pt3d_rot #(.ROT_W(ROT_W), .AXIS(AXIS_Z)) u_rot_z (
    .clk(clk), .ld(ld[3]), .rotate(rotate), .cs(param[2]), .p_in(r3), .p_out(r4)
  );

  // scale path runs alongside the rotations
  logic signed [DIFF_W-1:0] sd [3];
  logic signed [SCL_W-1:0]  sq [3];
  scl_ld_t                  scl_ld;

  for (genvar i = 0; i < 3; i++) begin : g_sd
    assign sd[i] = s1[i][DIFF_W-1:0];
  end

  assign scl_ld = '{st2: ld[1], st3: ld[2], st4: ld[3]};

  pt3d_scale #(.DIFF_W(DIFF_W), .SCL_W(SCL_W)) u_scale (
    .clk(clk), .ld(scl_ld), .d(sd), .k(param), .q(sq)
  );

  // stage 5
  pt3d_out #(.COORD_WIDTH(COORD_WIDTH), .ROT_W(ROT_W), .SCL_W(SCL_W)) u_out (
    .clk(clk), .ld(ld[4]), .mode(mode), .r(r4), .q(sq), .center(center),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .saturated(saturated)
  );

  // input is held off only while the output is stalled
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without an output stall");

  // occupancy changes by exactly the transfers in and out
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |->
      ($countones(vld) + ($past(out_valid && out_ready) ? 1 : 0) ==
       $past($countones(vld)) + ($past(in_valid && in_ready) ? 1 : 0)))
    else $error("pipeline occupancy lost or duplicated an item");

  // a clipped result carries a rail value in at least one coordinate
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (out_x == SAT_MAX || out_x == SAT_MIN ||
       out_y == SAT_MAX || out_y == SAT_MIN ||
       out_z == SAT_MAX || out_z == SAT_MIN))
    else $error("saturated set with no coordinate at a rail");

endmodule

`default_nettype wire

// ===== tb/pt3d_checker.sv =====
// Watches the point and register channels, predicts each transformed point and compares results.
`timescale 1ns / 100ps

module pt3d_checker
  import pt3d_pkg::*;
#(
  parameter int W = COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic signed [W-1:0]   in_x,
  input  logic signed [W-1:0]   in_y,
  input  logic signed [W-1:0]   in_z,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic signed [W-1:0]   out_x,
  input  logic signed [W-1:0]   out_y,
  input  logic signed [W-1:0]   out_z,
  input  logic                  saturated,
  input  logic                  wr_en,
  input  logic [REG_INDEX_W-1:0] wr_index,
  input  logic [REG_DATA_W-1:0] wr_data,
  output int                    errors,
  output int                    pending,
  output int                    checked
);

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
    logic                sat;
  } point_res_t;

  localparam logic signed [127:0] MAG_LIM = 128'sd1 <<< 62;

  // local copy of the register file
  logic [1:0]         cfg_mode = '0;
  logic signed [31:0] cfg_cx = '0, cfg_cy = '0, cfg_cz = '0;
  logic [31:0]        cfg_px = '0, cfg_py = '0, cfg_pz = '0;

  point_res_t predicted_pts[$];
  point_res_t want;
  int         err_cnt = 0;
  int         chk_cnt = 0;

  // exact product, floored to the target fraction, magnitude capped at 2^62
  function automatic logic signed [63:0] mul_floor(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input int sh);
    logic signed [127:0] la, lb, p;
    la = a;
    lb = b;
    p  = la * lb;
    p  = p >>> sh;
    if (p > MAG_LIM) p = MAG_LIM;
    else if (p < -MAG_LIM) p = -MAG_LIM;
    return p[63:0];
  endfunction

  // one planar rotation step; each term floored on its own
  function automatic logic [127:0] turn_pair(input logic signed [63:0] a,
                                             input logic signed [63:0] b,
                                             input logic [31:0] cs);
    logic signed [63:0] c, s, na, nb;
    c  = $signed(cs[2*CS_W-1:CS_W]);
    s  = $signed(cs[CS_W-1:0]);
    na = mul_floor(a, c, CS_FRAC) + mul_floor(b, s, CS_FRAC);
    nb = mul_floor(-a, s, CS_FRAC) + mul_floor(b, c, CS_FRAC);
    return {na, nb};
  endfunction

  // top bit flags clipping
  function automatic logic [W:0] clip_coord(input logic signed [63:0] v);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return {1'b1, hi[W-1:0]};
    if (v < lo) return {1'b1, lo[W-1:0]};
    return {1'b0, v[W-1:0]};
  endfunction

  function automatic point_res_t transform_point(input logic signed [W-1:0] px,
                                                 input logic signed [W-1:0] py,
                                                 input logic signed [W-1:0] pz);
    logic signed [63:0] x, y, z, cx, cy, cz, kx, ky, kz;
    logic [127:0]       r;
    logic [W:0]         cl;
    point_res_t         res;
    x  = px;
    y  = py;
    z  = pz;
    cx = cfg_cx;
    cy = cfg_cy;
    cz = cfg_cz;
    kx = $signed(cfg_px);
    ky = $signed(cfg_py);
    kz = $signed(cfg_pz);
    case (cfg_mode)
      MODE_MOVE: begin
        x = x + kx;
        y = y + ky;
        z = z + kz;
      end
      MODE_SCALE: begin
        x = mul_floor(x - cx, kx, Q_FRAC) + cx;
        y = mul_floor(y - cy, ky, Q_FRAC) + cy;
        z = mul_floor(z - cz, kz, Q_FRAC) + cz;
      end
      MODE_ROTATE: begin
        x = x - cx;
        y = y - cy;
        z = z - cz;
        r = turn_pair(y, z, cfg_px);
        y = r[127:64];
        z = r[63:0];
        r = turn_pair(x, z, cfg_py);
        x = r[127:64];
        z = r[63:0];
        r = turn_pair(x, y, cfg_pz);
        x = r[127:64];
        y = r[63:0];
        x = x + cx;
        y = y + cy;
        z = z + cz;
      end
      default: ;  // unused mode: point passes through
    endcase
    cl      = clip_coord(x);
    res.x   = cl[W-1:0];
    res.sat = cl[W];
    cl      = clip_coord(y);
    res.y   = cl[W-1:0];
    res.sat = res.sat | cl[W];
    cl      = clip_coord(z);
    res.z   = cl[W-1:0];
    res.sat = res.sat | cl[W];
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      predicted_pts.delete();
      cfg_mode = '0;
      cfg_cx   = '0;
      cfg_cy   = '0;
      cfg_cz   = '0;
      cfg_px   = '0;
      cfg_py   = '0;
      cfg_pz   = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_pts.size() == 0) begin
          err_cnt++;
          $error("result transfer with no prediction waiting: x=%0d y=%0d z=%0d",
                 out_x, out_y, out_z);
        end else begin
          want = predicted_pts.pop_front();
          chk_cnt++;
          if (out_x !== want.x) begin
            err_cnt++;
            $error("out_x: expected %0d, got %0d", want.x, out_x);
          end
          if (out_y !== want.y) begin
            err_cnt++;
            $error("out_y: expected %0d, got %0d", want.y, out_y);
          end
          if (out_z !== want.z) begin
            err_cnt++;
            $error("out_z: expected %0d, got %0d", want.z, out_z);
          end
          if (saturated !== want.sat) begin
            err_cnt++;
            $error("saturated: expected %0d, got %0d", want.sat, saturated);
          end
        end
      end
      // prediction uses the registers as they stood before this edge
      if (in_valid && in_ready) predicted_pts.push_back(transform_point(in_x, in_y, in_z));
      if (wr_en) begin
        case (wr_index)
          REG_MODE:     cfg_mode = wr_data[1:0];
          REG_CENTER_X: cfg_cx   = wr_data[31:0];
          REG_CENTER_Y: cfg_cy   = wr_data[31:0];
          REG_CENTER_Z: cfg_cz   = wr_data[31:0];
          REG_PARAM_X:  cfg_px   = wr_data[31:0];
          REG_PARAM_Y:  cfg_py   = wr_data[31:0];
          REG_PARAM_Z:  cfg_pz   = wr_data[31:0];
          default: ;
        endcase
      end
    end
    errors  <= err_cnt;
    checked <= chk_cnt;
    pending <= predicted_pts.size();
  end

endmodule

// ===== tb/point_transform_3d_tb.sv =====
// Top of the point transform testbench: clock, reset, register setup, point stimulus, verdict.
`timescale 1ns / 100ps

module point_transform_3d_tb;
  import pt3d_pkg::*;

  localparam int W             = COORD_WIDTH_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_POINTS  = 53;
  localparam int SETTLE_CYCLES = 8;

  localparam logic [REG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [31:0] RMAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] RMIN    = 32'h8000_0000;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [31:0] NEG_ONE = 32'hFFFF_FFFF;
  localparam logic [31:0] TURN_ID = {16'd16384, 16'd0};
  localparam logic [W-1:0] PMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] PMIN   = {1'b1, {(W-1){1'b0}}};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [W-1:0]    in_x = '0, in_y = '0, in_z = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b1;
  logic signed [W-1:0]    out_x, out_y, out_z;
  logic                   saturated;
  logic                   wr_en = 1'b0;
  logic [REG_INDEX_W-1:0] wr_index = '0;
  logic [REG_DATA_W-1:0]  wr_data = '0;

  int errors, pending, checked;
  int points_sent = 0;
  int settings    = 0;
  int cycle_count = 0;
  bit calm        = 1'b0;

  point_transform_3d #(.COORD_WIDTH(W)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .saturated(saturated),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  pt3d_checker #(.W(W)) pt_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .saturated(saturated),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .errors(errors), .pending(pending), .checked(checked)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("point_transform_3d_tb: errors");
      $finish;
    end
  end

  // receiver back-pressure in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0, 1:    return r;
      2:       return RMAX;
      3:       return RMIN;
      4:       return {{16{r[15]}}, r[15:0]};
      default: return {{8{r[23]}}, r[23:0]};
    endcase
  endfunction

  // mostly factors within +/-4.0
  function automatic logic [31:0] rand_scale();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
  endfunction

  // mostly a true cos/sin pair, now and then raw bits
  function automatic logic [31:0] rand_turn();
    real ang;
    int  c, s;
    if ($urandom_range(0, 4) == 0) return $urandom;
    ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
    c   = $rtoi($cos(ang) * 16384.0);
    s   = $rtoi($sin(ang) * 16384.0);
    return {c[15:0], s[15:0]};
  endfunction

  // leaves wr_en high; the caller lowers it after the last write
  task automatic write_reg(input logic [REG_INDEX_W-1:0] idx, input logic [31:0] d);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= d;
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] m,
                           input logic [31:0] cx, input logic [31:0] cy,
                           input logic [31:0] cz, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] pz,
                           input bit touch_unused);
    write_reg(REG_MODE, m);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_PARAM_X, px);
    write_reg(REG_PARAM_Y, py);
    write_reg(REG_PARAM_Z, pz);
    if (touch_unused) write_reg(REG_UNUSED, $urandom);
    wr_en <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  // valid stays up into the next point unless a gap follows
  task automatic send_point(input logic [W-1:0] x, input logic [W-1:0] y,
                            input logic [W-1:0] z);
    in_x     <= x;
    in_y     <= y;
    in_z     <= z;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    points_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // hold off until every predicted result has been seen, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] m, px, py, pz;
    int          pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: move by zero
    send_point('0, '0, '0);
    send_point(PMAX, PMIN, NEG_ONE);
    send_point(PMIN, PMAX, 32'd1);
    drain();

    // move with extreme offsets, clipping both ways
    configure(32'(MODE_MOVE), '0, '0, '0, RMAX, RMIN, 32'd1, 1'b0);
    send_point(PMAX, PMIN, PMAX);
    send_point(PMIN, PMAX, '0);
    send_point(32'd1, NEG_ONE, 32'd5);
    drain();

    // scale by 1, -1 and 0.5
    configure(32'(MODE_SCALE), '0, '0, '0, ONE_Q16, 32'hFFFF_0000, 32'h0000_8000, 1'b0);
    send_point(PMIN, 32'hFFFD_0000, 32'd3);
    send_point(PMAX, 32'd3, NEG_ONE);
    drain();

    configure(32'(MODE_SCALE), RMAX, RMIN, '0, RMAX, RMIN, '0, 1'b0);
    send_point(PMIN, PMAX, ONE_Q16);
    send_point('0, '0, '0);
    drain();

    // identity turn about an offset centre
    configure(32'(MODE_ROTATE), 32'h0010_0000, 32'hFFF0_0000, 32'd5,
              TURN_ID, TURN_ID, TURN_ID, 1'b0);
    send_point(PMAX, PMIN, 32'd12345);
    drain();

    // quarter turn about z
    configure(32'(MODE_ROTATE), '0, '0, '0, TURN_ID, TURN_ID, {16'd0, 16'd16384}, 1'b0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    drain();

    // extreme cos/sin halves and extreme centres
    configure(32'(MODE_ROTATE), RMIN, RMAX, '0, {16'h8000, 16'h7FFF},
              {16'h7FFF, 16'h8000}, {16'h8000, 16'h8000}, 1'b0);
    send_point(PMAX, PMAX, PMIN);
    send_point(PMIN, PMIN, PMAX);
    send_point('0, '0, '0);
    drain();

    // unused mode with junk in the upper bits, plus a write to the spare index
    configure(NEG_ONE, RMAX, RMIN, RMAX, $urandom, $urandom, $urandom, 1'b1);
    send_point(PMAX, PMIN, 32'd7);
    send_point(32'hFFFF_FFFB, 32'd5, '0);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm <= (ph >= RANDOM_PHASES - 2);
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        m  = 32'(MODE_MOVE);
        px = rand_coord();
        py = rand_coord();
        pz = rand_coord();
      end else if (pick < 6) begin
        m  = 32'(MODE_ROTATE);
        px = rand_turn();
        py = rand_turn();
        pz = rand_turn();
      end else if (pick < 9) begin
        m  = 32'(MODE_SCALE);
        px = rand_scale();
        py = rand_scale();
        pz = rand_scale();
      end else begin
        m  = 32'(MODE_UNUSED);
        px = $urandom;
        py = $urandom;
        pz = $urandom;
      end
      // upper bits of the mode word are don't-care
      m = ($urandom & ~32'd3) | m;
      configure(m, rand_coord(), rand_coord(), rand_coord(), px, py, pz,
                $urandom_range(0, 2) == 0);
      for (int i = 0; i < PHASE_POINTS; i++) begin
        send_point(rand_coord(), rand_coord(), rand_coord());
        if (ph == 2 && i == PHASE_POINTS / 2) drain();
      end
      drain();
    end

    if (pending != 0) $error("%0d predicted results never arrived", pending);
    $display("covered %0d points over %0d register settings (move, rotate, scale, unused mode)",
             points_sent, settings);
    $display("%0d result transfers compared field by field", checked);
    if (errors == 0 && pending == 0) begin
      $display("point_transform_3d_tb: clean");
    end else begin
      $display("point_transform_3d_tb: errors");
    end
    $finish;
  end

endmodule
